/* rtl/rcaf_pkg.sv */
// Shared types and constants for the RGB colour adjustment filter.
// No dependencies; rcaf_div, rcaf_hsv and the top level import this package.
`default_nettype none

package rcaf_pkg;

  localparam int CHAN_W     = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam int DIV_NW     = 24;   // numerator bits, one per divider stage
  localparam int HSV_STAGES = 7;
  localparam int SIDE_DEPTH = DIV_NW + HSV_STAGES;

  // Mode codes of the adjust_mode register
  localparam logic [2:0] MODE_PASS = 3'd0;
  localparam logic [2:0] MODE_DEC  = 3'd1;
  localparam logic [2:0] MODE_INC  = 3'd2;
  localparam logic [2:0] MODE_DESAT = 3'd3;
  localparam logic [2:0] MODE_GRAY = 3'd4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PCT  = 1'b1;

  localparam logic [6:0] PCT_RESET = 7'd50;
  localparam logic [6:0] PCT_MAX   = 7'd100;

  // 60 degrees in hue units (8 fractional bits)
  localparam logic [16:0] SPAN60 = 17'd15360;

  // Reciprocals for exact floor division by constants
  localparam logic [17:0] K_DIV100 = 18'd167773;   // >>24, x < 199728
  localparam logic [22:0] K_DIV25  = 23'd5368710;  // >>27, x < 6.1M
  localparam logic [20:0] K_DIV15  = 21'd1118482;  // >>24, x < 1.19M

  typedef enum logic [2:0] {
    SEL_RED   = 3'b001,
    SEL_GREEN = 3'b010,
    SEL_BLUE  = 3'b100
  } max_sel_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  // Hue/value information that travels alongside the dividers
  typedef struct packed {
    max_sel_t    sel;
    logic        dneg;
    logic        dzero;
    logic [16:0] v16;
    logic [6:0]  pct;
  } hsv_info_t;

  typedef struct packed {
    logic [2:0] mode;
    pix_t       pix;
    pix_t       simp;
    hsv_info_t  info;
  } side_t;

endpackage

`default_nettype wire

/* rtl/rcaf_if.sv */
// Valid/ready pixel channel interfaces for the colour adjustment filter.
// No dependencies.
`default_nettype none

interface rcaf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;
  modport source (output valid, in_red, in_green, in_blue, input ready);
  modport sink   (input valid, in_red, in_green, in_blue, output ready);
endinterface

interface rcaf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  modport source (output valid, out_red, out_green, out_blue, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, output ready);
endinterface

`default_nettype wire

/* rtl/rcaf_div.sv */
// Pipelined restoring divider, 24-bit numerator by 8-bit divisor,
// one quotient bit per stage. Depends on rcaf_pkg.
`default_nettype none

module rcaf_div import rcaf_pkg::*; (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [DIV_NW-1:0] num,
  input  wire logic [7:0]        den,
  output logic      [DIV_NW-1:0] quo
);

  logic [7:0]        rem_r [DIV_NW];
  logic [DIV_NW-1:0] num_r [DIV_NW];
  logic [DIV_NW-1:0] quo_r [DIV_NW];
  logic [7:0]        den_r [DIV_NW];

  for (genvar j = 0; j < DIV_NW; j++) begin : g_stage
    logic [7:0]        rem_in;
    logic [DIV_NW-1:0] num_in;
    logic [DIV_NW-1:0] quo_in;
    logic [7:0]        den_in;
    logic [8:0]        trial;
    logic              ge;

    if (j == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = num;
      assign quo_in = '0;
      assign den_in = den;
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign num_in = num_r[j-1];
      assign quo_in = quo_r[j-1];
      assign den_in = den_r[j-1];
    end

    // shift in next numerator bit, subtract when it fits
    assign trial = {rem_in, num_in[DIV_NW-1]};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= ge ? 8'(trial - {1'b0, den_in}) : trial[7:0];
        num_r[j] <= {num_in[DIV_NW-2:0], 1'b0};
        quo_r[j] <= {quo_in[DIV_NW-2:0], ge};
        den_r[j] <= den_in;
      end
    end
  end

  assign quo = quo_r[DIV_NW-1];

endmodule

`default_nettype wire

/* rtl/rcaf_hsv.sv */
// Desaturate back end: builds hue, scales saturation and converts HSV
// back to RGB over seven register stages. Depends on rcaf_pkg.
`default_nettype none

module rcaf_hsv import rcaf_pkg::*; (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [DIV_NW-1:0] s_quo,
  input  wire logic [DIV_NW-1:0] h_quo,
  input  wire hsv_info_t         info,
  output pix_t                   rgb
);

  // stage A: hue and S*(100-p)
  logic [16:0] h_r, va_r;
  logic [23:0] x100_r;
  logic [16:0] s16, hq, h_nxt;
  logic [6:0]  inv_pct;

  always_comb begin
    s16     = info.dzero ? 17'd0 : s_quo[16:0];
    hq      = {3'b0, h_quo[13:0]};
    inv_pct = 7'(PCT_MAX - info.pct);
    case (info.sel)
      SEL_RED:   h_nxt = info.dneg ? 17'(6 * SPAN60 - hq) : hq;
      SEL_GREEN: h_nxt = info.dneg ? 17'(2 * SPAN60 - hq) : 17'(2 * SPAN60 + hq);
      SEL_BLUE:  h_nxt = info.dneg ? 17'(4 * SPAN60 - hq) : 17'(4 * SPAN60 + hq);
      default:   h_nxt = '0;
    endcase
    if (info.dzero) h_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_r    <= h_nxt;
      va_r   <= info.v16;
      x100_r <= s16 * inv_pct;
    end
  end

  // stage B: S' = x100/100, sector and triangle term
  logic [16:0] s2_r, vb_r;
  logic [2:0]  secb_r;
  logic [14:0] trib_r;
  logic [44:0] s2_prod;
  logic [2:0]  sec_nxt;
  logic [16:0] t_val;

  always_comb begin
    s2_prod = x100_r[23:2] * K_DIV25;
    if      (h_r >= 17'(5 * SPAN60)) sec_nxt = 3'd5;
    else if (h_r >= 17'(4 * SPAN60)) sec_nxt = 3'd4;
    else if (h_r >= 17'(3 * SPAN60)) sec_nxt = 3'd3;
    else if (h_r >= 17'(2 * SPAN60)) sec_nxt = 3'd2;
    else if (h_r >= SPAN60)          sec_nxt = 3'd1;
    else                             sec_nxt = 3'd0;
    // h mod 120 degrees
    case (sec_nxt[2:1])
      2'd0:    t_val = h_r;
      2'd1:    t_val = 17'(h_r - 2 * SPAN60);
      default: t_val = 17'(h_r - 4 * SPAN60);
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r   <= s2_prod[43:27];
      vb_r   <= va_r;
      secb_r <= sec_nxt;
      trib_r <= (t_val >= SPAN60) ? 15'(2 * SPAN60 - t_val) : t_val[14:0];
    end
  end

  // stage C: chroma
  logic [16:0] c_r, vc_r;
  logic [2:0]  secc_r;
  logic [14:0] tric_r;
  logic [33:0] c_prod;

  assign c_prod = vb_r * s2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      c_r    <= c_prod[32:16];
      vc_r   <= vb_r;
      secc_r <= secb_r;
      tric_r <= trib_r;
    end
  end

  // stage D: C*tri/1024 and M
  logic [19:0] z_r;
  logic [16:0] cd_r, md_r;
  logic [2:0]  secd_r;
  logic [31:0] z_prod;

  assign z_prod = c_r * tric_r;

  always_ff @(posedge clk) begin
    if (en) begin
      z_r    <= z_prod[29:10];
      cd_r   <= c_r;
      md_r   <= 17'(vc_r - c_r);
      secd_r <= secc_r;
    end
  end

  // stage E: X = z/15
  logic [16:0] x_r, ce_r, me_r;
  logic [2:0]  sece_r;
  logic [40:0] x_prod;

  assign x_prod = z_r * K_DIV15;

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_prod[40:24];
      ce_r   <= cd_r;
      me_r   <= md_r;
      sece_r <= secd_r;
    end
  end

  // stage F: six-sector rule plus M
  logic [16:0] qr_r, qg_r, qb_r;
  logic [16:0] rp, gp, bp;

  always_comb begin
    case (sece_r)
      3'd0:    begin rp = ce_r;  gp = x_r;   bp = '0;    end
      3'd1:    begin rp = x_r;   gp = ce_r;  bp = '0;    end
      3'd2:    begin rp = '0;    gp = ce_r;  bp = x_r;   end
      3'd3:    begin rp = '0;    gp = x_r;   bp = ce_r;  end
      3'd4:    begin rp = x_r;   gp = '0;    bp = ce_r;  end
      default: begin rp = ce_r;  gp = '0;    bp = x_r;   end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qr_r <= 17'(rp + me_r);
      qg_r <= 17'(gp + me_r);
      qb_r <= 17'(bp + me_r);
    end
  end

  // stage G: Q16 to 8-bit channel, (q*255)>>16 clipped
  function automatic logic [7:0] to_chan(input logic [16:0] q);
    logic [24:0] p;
    begin
      p = {q, 8'b0} - {8'b0, q};
      to_chan = p[24] ? 8'hff : p[23:16];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      rgb.red   <= to_chan(qr_r);
      rgb.green <= to_chan(qg_r);
      rgb.blue  <= to_chan(qb_r);
    end
  end

endmodule

`default_nettype wire

/* rtl/rgb_color_adjust_filter_top.sv */
// RGB colour adjustment filter, top level.
// Uses rcaf_pkg, rcaf_if, rcaf_div and rcaf_hsv.
//
// Usage:
//   in_pix  : valid/ready channel, one 8-bit RGB pixel per beat.
//   out_pix : valid/ready channel, one adjusted pixel per input beat,
//             in order.
//   cfg_*   : write port; index 0 adjust_mode, index 1 factor_percent.
//             Write only while no pixel is in flight.
// Pipeline: there are 34 register stages, the first clocked by the edge that
// accepts the input beat: two front stages, 24 divider stages (one quotient
// bit each), seven HSV-to-RGB stages and the output register. Throughput is
// one pixel per clock while the skid register is empty, set by the fully
// pipelined dividers and multipliers.
// All stages advance together while the skid register is empty. When
// out_pix stalls, the pipeline keeps moving until a pixel reaches its end
// with the output register full; that pixel goes into the skid register and
// in_pix.ready drops until the output takes a beat and the skid drains.
// Synchronous reset clears all valid bits, sets mode to pass-through and
// factor to 50 percent.
`default_nettype none

module rgb_color_adjust_filter_top import rcaf_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  rcaf_in_if.sink                    in_pix,
  rcaf_out_if.source                 out_pix,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration registers
  logic [2:0] mode_r;
  logic [6:0] pct_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_PASS;
      pct_r  <= PCT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE: mode_r <= cfg_data[2:0];
        REG_PCT:  pct_r  <= cfg_data;
        default:  ;
      endcase
    end
  end

  // pipeline advance: held only while the skid register is full
  logic skv_r;
  logic en;
  assign en           = !skv_r;
  assign in_pix.ready = en;

  // stage 0: capture beat
  logic       v0_r;
  pix_t       px0_r;
  logic [2:0] mode0_r;
  logic [6:0] pct0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else if (en) v0_r <= in_pix.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px0_r   <= '{in_pix.in_red, in_pix.in_green, in_pix.in_blue};
      mode0_r <= mode_r;
      pct0_r  <= (pct_r > PCT_MAX) ? PCT_MAX : pct_r;
    end
  end

  // stage 1: max/min, hue difference, V, simple-mode product
  logic [7:0] mx, mn, ha, hb, dabs;
  max_sel_t   sel;
  logic [7:0] fac, ch_r, ch_g, ch_b;

  always_comb begin
    mx = px0_r.red;
    if (px0_r.green > mx) mx = px0_r.green;
    if (px0_r.blue  > mx) mx = px0_r.blue;
    mn = px0_r.red;
    if (px0_r.green < mn) mn = px0_r.green;
    if (px0_r.blue  < mn) mn = px0_r.blue;
    if (mx == px0_r.red) begin
      sel = SEL_RED;   ha = px0_r.green; hb = px0_r.blue;
    end else if (mx == px0_r.green) begin
      sel = SEL_GREEN; ha = px0_r.blue;  hb = px0_r.red;
    end else begin
      sel = SEL_BLUE;  ha = px0_r.red;   hb = px0_r.green;
    end
    dabs = (ha >= hb) ? 8'(ha - hb) : 8'(hb - ha);
    fac  = (mode0_r == MODE_INC) ? 8'(PCT_MAX + pct0_r) : 8'(PCT_MAX - pct0_r);
    ch_r = (mode0_r == MODE_GRAY) ? mx : px0_r.red;
    ch_g = (mode0_r == MODE_GRAY) ? mx : px0_r.green;
    ch_b = (mode0_r == MODE_GRAY) ? mx : px0_r.blue;
  end

  logic        v1_r;
  logic [2:0]  mode1_r;
  pix_t        px1_r;
  hsv_info_t   info1_r;
  logic [7:0]  mx1_r, delta1_r, dabs1_r;
  logic [15:0] spr_r, spg_r, spb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= v0_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode1_r       <= mode0_r;
      px1_r         <= px0_r;
      mx1_r         <= mx;
      delta1_r      <= 8'(mx - mn);
      dabs1_r       <= dabs;
      info1_r.sel   <= sel;
      info1_r.dneg  <= ha < hb;
      info1_r.dzero <= mx == mn;
      info1_r.v16   <= 17'({mx, 8'b0} + mx + (mx != 8'd0));
      info1_r.pct   <= pct0_r;
      spr_r         <= ch_r * fac;
      spg_r         <= ch_g * fac;
      spb_r         <= ch_b * fac;
    end
  end

  // simple modes: product/100, clipped at 255
  function automatic logic [7:0] div100_sat(input logic [15:0] x);
    logic [33:0] p;
    begin
      p = x * K_DIV100;
      div100_sat = (p[33:24] > 10'd255) ? 8'hff : p[31:24];
    end
  endfunction

  // dividers: S = delta*65536/max, hue offset = 15360*|diff|/delta
  logic [DIV_NW-1:0] s_quo, h_quo;
  logic [11:0]       d15;
  assign d15 = {dabs1_r, 4'b0} - {4'b0, dabs1_r};

  rcaf_div u_div_s (
    .clk (clk), .en (en),
    .num ({delta1_r, 16'b0}), .den (mx1_r), .quo (s_quo)
  );

  rcaf_div u_div_h (
    .clk (clk), .en (en),
    .num ({2'b0, d15, 10'b0}), .den (delta1_r), .quo (h_quo)
  );

  // side line keeps each pixel's context level with the dividers and HSV stages
  side_t side_r [SIDE_DEPTH];
  logic  sv_r   [SIDE_DEPTH];

  for (genvar j = 0; j < SIDE_DEPTH; j++) begin : g_side
    always_ff @(posedge clk) begin
      if (!rst_n) sv_r[j] <= 1'b0;
      else if (en) sv_r[j] <= (j == 0) ? v1_r : sv_r[(j == 0) ? 0 : j-1];
    end
    if (j == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (en) begin
          side_r[0].mode       <= mode1_r;
          side_r[0].pix        <= px1_r;
          side_r[0].info       <= info1_r;
          side_r[0].simp.red   <= div100_sat(spr_r);
          side_r[0].simp.green <= div100_sat(spg_r);
          side_r[0].simp.blue  <= div100_sat(spb_r);
        end
      end
    end else begin : g_tail
      always_ff @(posedge clk) begin
        if (en) side_r[j] <= side_r[j-1];
      end
    end
  end

  pix_t hsv_px;

  rcaf_hsv u_hsv (
    .clk   (clk),
    .en    (en),
    .s_quo (s_quo),
    .h_quo (h_quo),
    .info  (side_r[DIV_NW-1].info),
    .rgb   (hsv_px)
  );

  // result select
  logic  pv;
  pix_t  pd;
  side_t last;

  always_comb begin
    last = side_r[SIDE_DEPTH-1];
    pv   = sv_r[SIDE_DEPTH-1];
    case (last.mode)
      MODE_DEC, MODE_INC, MODE_GRAY: pd = last.simp;
      MODE_DESAT:                    pd = hsv_px;
      default:                       pd = last.pix;
    endcase
  end

  // output register and skid register
  logic ov_r;
  pix_t od_r, skd_r;
  logic fire;
  assign fire = ov_r && out_pix.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r  <= 1'b0;
      skv_r <= 1'b0;
    end else if (skv_r) begin
      if (fire) begin
        od_r  <= skd_r;
        skv_r <= 1'b0;
      end
    end else if (pv) begin
      if (!ov_r || fire) begin
        od_r <= pd;
        ov_r <= 1'b1;
      end else begin
        skd_r <= pd;
        skv_r <= 1'b1;
      end
    end else if (fire) begin
      ov_r <= 1'b0;
    end
  end

  assign out_pix.valid     = ov_r;
  assign out_pix.out_red   = od_r.red;
  assign out_pix.out_green = od_r.green;
  assign out_pix.out_blue  = od_r.blue;

endmodule

`default_nettype wire
